### hw/rtl/bbpg_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types of the buzzer beep pattern generator.
package bbpg_pkg;

  localparam int unsigned OpW     = 2;
  localparam int unsigned AdvW    = 10;
  localparam int unsigned MsW     = 16;
  localparam int unsigned CntInW  = 8;
  localparam int unsigned PctW    = 7;
  localparam int unsigned TotW    = 14;
  localparam int unsigned GapW    = 14;
  localparam int unsigned CntW    = 4;
  localparam int unsigned DivW    = 23;
  localparam int unsigned DivsW   = 7;
  localparam int unsigned DivCntW = 5;
  localparam int unsigned ApbAw   = 3;
  localparam int unsigned ApbDw   = 32;

  localparam logic [MsW-1:0]    TotMin      = 16'd10;
  localparam logic [MsW-1:0]    TotMax      = 16'd10000;
  localparam logic [MsW-1:0]    GapMax      = 16'd5000;
  localparam logic [CntInW-1:0] CntMax      = 8'd10;
  localparam logic [MsW-1:0]    StartPctMax = 16'd90;
  localparam logic [PctW-1:0]   PctMax      = 7'd100;
  localparam logic [DivsW-1:0]  PctDivisor  = 7'd100;
  localparam logic [PctW-1:0]   PctReset    = 7'd50;

  localparam logic [ApbAw-3:0]  RegDefaultGap = 1'd0;

  typedef enum logic [OpW-1:0] {
    OP_TICK      = 2'd0,
    OP_START_MS  = 2'd1,
    OP_START_PCT = 2'd2,
    OP_STOP      = 2'd3
  } opcode_e;

  typedef struct packed {
    logic             start;
    logic [DivW-1:0]  dividend;
    logic [DivsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] quotient;
  } div_rsp_t;

endpackage

### hw/rtl/bbpg_cmd_if.sv
`timescale 1ns / 1ps
// Command channel interface of the buzzer beep pattern generator.
interface bbpg_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [bbpg_pkg::OpW-1:0]      opcode;
  logic [bbpg_pkg::AdvW-1:0]     advance_ms;
  logic [bbpg_pkg::MsW-1:0]      period_ms;
  logic [bbpg_pkg::MsW-1:0]      on_time_ms;
  logic [bbpg_pkg::CntInW-1:0]   repeat_count;
  logic [bbpg_pkg::MsW-1:0]      gap_value;

  modport source (output valid, opcode, advance_ms, period_ms, on_time_ms, repeat_count,
                  gap_value, input ready);
  modport sink (input valid, opcode, advance_ms, period_ms, on_time_ms, repeat_count,
                gap_value, output ready);
endinterface

### hw/rtl/bbpg_res_if.sv
`timescale 1ns / 1ps
// Result channel interface of the buzzer beep pattern generator.
interface bbpg_res_if;
  logic valid;
  logic ready;
  logic buzzer_level;
  logic pattern_running;

  modport source (output valid, buzzer_level, pattern_running, input ready);
  modport sink (input valid, buzzer_level, pattern_running, output ready);
endinterface

### hw/rtl/buzzer_beep_pattern_generator.sv
`timescale 1ns / 1ps
// Buzzer beep pattern generator: one result beat for every command beat.
// A tick or a stop command has its result registered as the command is taken, so ticks
// can follow one another every cycle while the result side keeps up. A start command
// runs through a small sequencer around one shared 23-bit divider that yields one
// quotient bit per cycle. A start that ends up with a single pulse needs no division.
// Otherwise a start with the gap in milliseconds needs one division, a start with a gap
// percent adds one, and gaps that would use up the on time add two more. No command is
// taken while a start runs. Configuration writes are taken at any time.
module buzzer_beep_pattern_generator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bbpg_cmd_if.sink                      cmd_i,
  bbpg_res_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bbpg_pkg::ApbAw-1:0]    paddr,
  input  logic [bbpg_pkg::ApbDw-1:0]    pwdata,
  output logic [bbpg_pkg::ApbDw-1:0]    prdata,
  output logic                          pready
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PCT    = 6'b000010,
    ST_CHECK  = 6'b000100,
    ST_DEF100 = 6'b001000,
    ST_DEFCNT = 6'b010000,
    ST_PULSE  = 6'b100000
  } seq_e;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_PULSE  = 4'b0010,
    PH_GAP    = 4'b0100,
    PH_PERIOD = 4'b1000
  } phase_e;

  logic [bbpg_pkg::PctW-1:0]  pct;
  bbpg_pkg::div_req_t         div_req;
  bbpg_pkg::div_rsp_t         div_rsp;

  seq_e                       st_q, st_d;
  logic                       redo_q, redo_d;
  phase_e                     ph_q, ph_d;
  logic                       run_q, run_d;
  logic                       buz_q, buz_d;
  logic [bbpg_pkg::MsW-1:0]   el_q, el_d;
  logic [bbpg_pkg::TotW-1:0]  tot_q, tot_d;
  logic [bbpg_pkg::GapW-1:0]  gap_q, gap_d;
  logic [bbpg_pkg::TotW-1:0]  pls_q, pls_d;
  logic [bbpg_pkg::MsW-1:0]   per_q, per_d;
  logic [bbpg_pkg::CntW-1:0]  ptot_q, ptot_d;
  logic [bbpg_pkg::CntW-1:0]  pnum_q, pnum_d;
  logic                       res_valid_q;
  logic                       res_buz_q, res_run_q;
  logic                       res_load;
  logic                       res_buz_d, res_run_d;

  logic                       cmd_fire;
  bbpg_pkg::opcode_e          op;
  logic [bbpg_pkg::MsW:0]     el_sum;
  logic [bbpg_pkg::MsW-1:0]   el_sat;
  logic [bbpg_pkg::TotW-1:0]  tot_c;
  logic [bbpg_pkg::CntW-1:0]  cnt_c;
  logic [bbpg_pkg::GapW-1:0]  gap_ms_c;
  logic [bbpg_pkg::PctW-1:0]  pctg;
  logic [bbpg_pkg::DivW-1:0]  pct_prod;
  logic [bbpg_pkg::GapW-1:0]  q_gap_c;
  logic [bbpg_pkg::CntW-1:0]  cntm1;
  logic [bbpg_pkg::TotW+3:0]  gapsum;
  logic                       too_long;
  logic [bbpg_pkg::DivW-1:0]  def_prod;
  logic [bbpg_pkg::CntW:0]    cnt_odd;

  bbpg_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pct_o   (pct)
  );

  bbpg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cmd_i.ready = (st_q == ST_IDLE) && (!res_valid_q || res_o.ready);
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;
  assign op          = bbpg_pkg::opcode_e'(cmd_i.opcode);

  assign res_o.valid           = res_valid_q;
  assign res_o.buzzer_level    = res_buz_q;
  assign res_o.pattern_running = res_run_q;

  assign el_sum = {1'b0, el_q} + (bbpg_pkg::MsW + 1)'(cmd_i.advance_ms);
  assign el_sat = el_sum[bbpg_pkg::MsW] ? '1 : el_sum[bbpg_pkg::MsW-1:0];

  assign tot_c = (cmd_i.on_time_ms < bbpg_pkg::TotMin) ? bbpg_pkg::TotW'(bbpg_pkg::TotMin) :
                 (cmd_i.on_time_ms > bbpg_pkg::TotMax) ? bbpg_pkg::TotW'(bbpg_pkg::TotMax) :
                 cmd_i.on_time_ms[bbpg_pkg::TotW-1:0];
  assign cnt_c = (cmd_i.repeat_count == '0) ? bbpg_pkg::CntW'(1) :
                 (cmd_i.repeat_count > bbpg_pkg::CntMax) ? bbpg_pkg::CntW'(bbpg_pkg::CntMax) :
                 cmd_i.repeat_count[bbpg_pkg::CntW-1:0];
  assign gap_ms_c = (cmd_i.gap_value > bbpg_pkg::GapMax) ? bbpg_pkg::GapW'(bbpg_pkg::GapMax) :
                    cmd_i.gap_value[bbpg_pkg::GapW-1:0];
  assign pctg = (cmd_i.gap_value > bbpg_pkg::StartPctMax) ?
                bbpg_pkg::PctW'(bbpg_pkg::StartPctMax) : cmd_i.gap_value[bbpg_pkg::PctW-1:0];
  assign pct_prod = bbpg_pkg::DivW'(cmd_i.on_time_ms) * bbpg_pkg::DivW'(pctg);
  assign q_gap_c  = (div_rsp.quotient > bbpg_pkg::DivW'(bbpg_pkg::GapMax)) ?
                    bbpg_pkg::GapW'(bbpg_pkg::GapMax) : div_rsp.quotient[bbpg_pkg::GapW-1:0];

  assign cntm1    = ptot_q - 1'b1;
  assign gapsum   = (bbpg_pkg::TotW + 4)'(gap_q) * (bbpg_pkg::TotW + 4)'(cntm1);
  assign too_long = (ptot_q > bbpg_pkg::CntW'(1)) &&
                    (gapsum >= (bbpg_pkg::TotW + 4)'(tot_q));
  assign def_prod = bbpg_pkg::DivW'(tot_q) * bbpg_pkg::DivW'(pct);
  assign cnt_odd  = {ptot_q, 1'b0} - 1'b1;

  always_comb begin
    st_d      = st_q;
    redo_d    = redo_q;
    ph_d      = ph_q;
    run_d     = run_q;
    buz_d     = buz_q;
    el_d      = el_q;
    tot_d     = tot_q;
    gap_d     = gap_q;
    pls_d     = pls_q;
    per_d     = per_q;
    ptot_d    = ptot_q;
    pnum_d    = pnum_q;
    div_req   = '0;
    res_load  = 1'b0;
    res_buz_d = buz_q;
    res_run_d = run_q;

    case (st_q)
      ST_IDLE: begin
        if (cmd_fire) begin
          case (op)
            bbpg_pkg::OP_TICK: begin
              if (run_q) begin
                el_d = el_sat;
                case (ph_q)
                  PH_PULSE: begin
                    if (el_sat >= bbpg_pkg::MsW'(pls_q)) begin
                      buz_d = 1'b0;
                      if (({1'b0, pnum_q} + 1'b1) < {1'b0, ptot_q}) begin
                        ph_d = PH_GAP;
                        el_d = '0;
                      end else if (per_q == '0 || per_q <= bbpg_pkg::MsW'(tot_q)) begin
                        run_d = 1'b0;
                        ph_d  = PH_IDLE;
                      end else begin
                        ph_d = PH_PERIOD;
                        el_d = '0;
                      end
                    end
                  end
                  PH_GAP: begin
                    if (el_sat >= bbpg_pkg::MsW'(gap_q)) begin
                      pnum_d = pnum_q + 1'b1;
                      ph_d   = PH_PULSE;
                      el_d   = '0;
                      buz_d  = 1'b1;
                    end
                  end
                  PH_PERIOD: begin
                    if (el_sat >= (per_q - bbpg_pkg::MsW'(tot_q))) begin
                      run_d = 1'b0;
                      ph_d  = PH_IDLE;
                    end
                  end
                  default: begin
                    run_d = 1'b0;
                  end
                endcase
              end
              res_load  = 1'b1;
              res_buz_d = buz_d;
              res_run_d = run_d;
            end
            bbpg_pkg::OP_STOP: begin
              buz_d     = 1'b0;
              ph_d      = PH_IDLE;
              run_d     = 1'b0;
              res_load  = 1'b1;
              res_buz_d = 1'b0;
              res_run_d = 1'b0;
            end
            bbpg_pkg::OP_START_MS: begin
              tot_d  = tot_c;
              ptot_d = cnt_c;
              per_d  = cmd_i.period_ms;
              gap_d  = gap_ms_c;
              redo_d = 1'b0;
              st_d   = ST_CHECK;
            end
            bbpg_pkg::OP_START_PCT: begin
              tot_d  = tot_c;
              ptot_d = cnt_c;
              per_d  = cmd_i.period_ms;
              gap_d  = '0;
              redo_d = 1'b0;
              if (cmd_i.repeat_count > bbpg_pkg::CntInW'(1)) begin
                div_req.start    = 1'b1;
                div_req.dividend = pct_prod;
                div_req.divisor  = bbpg_pkg::PctDivisor;
                st_d             = ST_PCT;
              end else begin
                st_d = ST_CHECK;
              end
            end
            default: begin
              st_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_PCT: begin
        if (div_rsp.done) begin
          gap_d = q_gap_c;
          st_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (too_long && !redo_q) begin
          redo_d           = 1'b1;
          div_req.start    = 1'b1;
          div_req.dividend = def_prod;
          div_req.divisor  = bbpg_pkg::PctDivisor;
          st_d             = ST_DEF100;
        end else if (ptot_q <= bbpg_pkg::CntW'(1)) begin
          pls_d     = tot_q;
          pnum_d    = '0;
          el_d      = '0;
          ph_d      = PH_PULSE;
          run_d     = 1'b1;
          buz_d     = 1'b1;
          res_load  = 1'b1;
          res_buz_d = 1'b1;
          res_run_d = 1'b1;
          st_d      = ST_IDLE;
        end else begin
          div_req.start = 1'b1;
          if (too_long) begin
            div_req.dividend = bbpg_pkg::DivW'(tot_q);
            div_req.divisor  = bbpg_pkg::DivsW'(cnt_odd);
          end else begin
            div_req.dividend = bbpg_pkg::DivW'(tot_q - gapsum[bbpg_pkg::TotW-1:0]);
            div_req.divisor  = bbpg_pkg::DivsW'(ptot_q);
          end
          st_d = ST_PULSE;
        end
      end
      ST_DEF100: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.quotient;
          div_req.divisor  = bbpg_pkg::DivsW'(cntm1);
          st_d             = ST_DEFCNT;
        end
      end
      ST_DEFCNT: begin
        if (div_rsp.done) begin
          gap_d = div_rsp.quotient[bbpg_pkg::GapW-1:0];
          st_d  = ST_CHECK;
        end
      end
      ST_PULSE: begin
        if (div_rsp.done) begin
          pls_d     = div_rsp.quotient[bbpg_pkg::TotW-1:0];
          pnum_d    = '0;
          el_d      = '0;
          ph_d      = PH_PULSE;
          run_d     = 1'b1;
          buz_d     = 1'b1;
          res_load  = 1'b1;
          res_buz_d = 1'b1;
          res_run_d = 1'b1;
          st_d      = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      redo_q      <= 1'b0;
      ph_q        <= PH_IDLE;
      run_q       <= 1'b0;
      buz_q       <= 1'b0;
      el_q        <= '0;
      tot_q       <= '0;
      gap_q       <= '0;
      pls_q       <= '0;
      per_q       <= '0;
      ptot_q      <= '0;
      pnum_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      redo_q <= redo_d;
      ph_q   <= ph_d;
      run_q  <= run_d;
      buz_q  <= buz_d;
      el_q   <= el_d;
      tot_q  <= tot_d;
      gap_q  <= gap_d;
      pls_q  <= pls_d;
      per_q  <= per_d;
      ptot_q <= ptot_d;
      pnum_q <= pnum_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_buz_q <= res_buz_d;
      res_run_q <= res_run_d;
    end
  end

endmodule

### hw/rtl/bbpg_apb_regs.sv
`timescale 1ns / 1ps
// APB configuration register holding the default gap percent.
module bbpg_apb_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bbpg_pkg::ApbAw-1:0]    paddr,
  input  logic [bbpg_pkg::ApbDw-1:0]    pwdata,
  output logic [bbpg_pkg::ApbDw-1:0]    prdata,
  output logic                          pready,
  output logic [bbpg_pkg::PctW-1:0]     pct_o
);

  logic [bbpg_pkg::PctW-1:0] pct_q;
  logic                      hit;

  assign hit    = (paddr[bbpg_pkg::ApbAw-1:2] == bbpg_pkg::RegDefaultGap);
  assign pready = 1'b1;
  assign prdata = hit ? bbpg_pkg::ApbDw'(pct_q) : '0;
  assign pct_o  = (pct_q > bbpg_pkg::PctMax) ? bbpg_pkg::PctMax : pct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q <= bbpg_pkg::PctReset;
    end else if (psel && penable && pwrite && hit) begin
      pct_q <= pwdata[bbpg_pkg::PctW-1:0];
    end
  end

endmodule

### hw/rtl/bbpg_div.sv
`timescale 1ns / 1ps
// Shared restoring divider that produces one quotient bit per cycle.
module bbpg_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bbpg_pkg::div_req_t req_i,
  output bbpg_pkg::div_rsp_t rsp_o
);

  logic                            busy_q;
  logic                            done_q;
  logic [bbpg_pkg::DivCntW-1:0]    cnt_q;
  logic [bbpg_pkg::DivW-1:0]       dvd_q;
  logic [bbpg_pkg::DivsW-1:0]      rem_q;
  logic [bbpg_pkg::DivsW-1:0]      dvs_q;
  logic [bbpg_pkg::DivsW:0]        shifted;
  logic [bbpg_pkg::DivsW:0]        diff;
  logic                            ge;
  logic [bbpg_pkg::DivsW-1:0]      rem_n;

  assign shifted = {rem_q, dvd_q[bbpg_pkg::DivW-1]};
  assign ge      = (shifted >= {1'b0, dvs_q});
  assign diff    = shifted - {1'b0, dvs_q};
  assign rem_n   = ge ? diff[bbpg_pkg::DivsW-1:0] : shifted[bbpg_pkg::DivsW-1:0];

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == bbpg_pkg::DivCntW'(bbpg_pkg::DivW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[bbpg_pkg::DivW-2:0], ge};
      rem_q <= rem_n;
    end
  end

endmodule
